### sv/signed_int_to_decimal_ascii_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the signed integer to decimal text converter
// Shared helpers that wrap a clocked property with a disable-on-reset guard.
// ----------------------------------------------------------------------------
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define S2D_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("s2d checker: same-cycle property failed");

// Antecedent implies consequent in the following cycle.
`define S2D_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("s2d checker: next-cycle property failed");

`endif

### sv/s2d_pkg.sv
// ----------------------------------------------------------------------------
// s2d_pkg
// Widths, character codes and shared types of the decimal text converter.
// ----------------------------------------------------------------------------
package s2d_pkg;

  localparam int DATA_W      = 32;
  localparam int CHAR_W      = 8;
  localparam int NUM_DIGITS  = 10;
  localparam int MAX_CHARS   = NUM_DIGITS + 1;
  localparam int BCD_W       = NUM_DIGITS * 4;
  localparam int DIGIT_IDX_W = $clog2(NUM_DIGITS);
  localparam int CHAR_CNT_W  = $clog2(MAX_CHARS + 1);

  // Two magnitude bits are folded into the BCD register per cycle.
  localparam int CONV_STEPS  = DATA_W / 2;
  localparam int STEP_CNT_W  = $clog2(CONV_STEPS + 1);

  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;

  typedef struct packed {
    logic              neg;
    logic [DATA_W-1:0] mag;
  } job_t;

endpackage

### sv/s2d_if.sv
// ----------------------------------------------------------------------------
// s2d stream interfaces
// Valid/ready channels for the input numbers and the output characters.
// ----------------------------------------------------------------------------
interface s2d_num_if;
  logic                               valid;
  logic                               ready;
  logic signed [s2d_pkg::DATA_W-1:0]  value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface s2d_text_if;
  logic                          valid;
  logic                          ready;
  logic [s2d_pkg::CHAR_W-1:0]    character;
  logic                          last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

### sv/signed_int_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Signed 32-bit integer to decimal ASCII text, one character per transaction.
// ----------------------------------------------------------------------------
//   Channel  Direction  Payload                  Transaction
//   num      in         value (32 bit, signed)   one number
//   text     out        character (8), last (1)  one character, last on final
//
// A number is taken from the queue in the idle state, converted in the
// two-bits-per-cycle binary-to-BCD converter, then sent one character per
// cycle while text is ready (1 to 11 characters); no new number is taken
// until its last character is sent. The job queue takes up to QUEUE_DEPTH
// numbers while the back end works or stalls.
// Reset empties the queue and returns the sequencer to idle.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii #(
  parameter int QUEUE_DEPTH = s2d_pkg::QUEUE_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  s2d_num_if.sink      num,
  s2d_text_if.source   text
);

  s2d_pkg::job_t  front_job;
  logic           front_valid;
  logic           front_ready;
  s2d_pkg::job_t  back_job;
  logic           back_valid;
  logic           back_ready;

  s2d_front u_front (
    .num       (num),
    .job       (front_job),
    .job_valid (front_valid),
    .job_ready (front_ready)
  );

  s2d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_job   (front_job),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .pop_job    (back_job),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready)
  );

  s2d_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (back_job),
    .job_valid (back_valid),
    .job_ready (back_ready),
    .text      (text)
  );

endmodule

### sv/s2d_front.sv
// ----------------------------------------------------------------------------
// s2d_front
// Accepts numbers and splits each into a sign and an unsigned magnitude.
// ----------------------------------------------------------------------------
module s2d_front (
  s2d_num_if.sink        num,
  output s2d_pkg::job_t  job,
  output logic           job_valid,
  input  logic           job_ready
);

  logic [s2d_pkg::DATA_W-1:0] raw;

  // The magnitude is taken unsigned, so the most negative number stays exact.
  always_comb begin
    raw      = unsigned'(num.value);
    job.neg  = raw[s2d_pkg::DATA_W-1];
    job.mag  = job.neg ? (s2d_pkg::DATA_W'(0) - raw) : raw;
  end

  assign job_valid = num.valid;
  assign num.ready = job_ready;

endmodule

### sv/s2d_queue.sv
// ----------------------------------------------------------------------------
// s2d_queue
// Short first-in first-out queue of jobs between the front and back parts.
// ----------------------------------------------------------------------------
module s2d_queue #(
  parameter int DEPTH = s2d_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  s2d_pkg::job_t  push_job,
  input  logic           push_valid,
  output logic           push_ready,
  output s2d_pkg::job_t  pop_job,
  output logic           pop_valid,
  input  logic           pop_ready
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  s2d_pkg::job_t     slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  fill;
  logic              push;
  logic              pop;

  assign push_ready = (fill != CNT_W'(DEPTH));
  assign pop_valid  = (fill != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_job    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

### sv/s2d_back.sv
// ----------------------------------------------------------------------------
// s2d_back
// Converts a magnitude to BCD by shift-and-add-three, then sends the sign and
// the significant digits one character per transaction.
// ----------------------------------------------------------------------------
module s2d_back (
  input  logic           clk,
  input  logic           rst,
  input  s2d_pkg::job_t  job,
  input  logic           job_valid,
  output logic           job_ready,
  s2d_text_if.source     text
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CONV = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t                             state;
  logic [s2d_pkg::DATA_W-1:0]         shreg;
  logic [s2d_pkg::BCD_W-1:0]          bcd;
  logic [s2d_pkg::BCD_W-1:0]          bcd_next;
  logic                               neg_pend;
  logic [s2d_pkg::DIGIT_IDX_W-1:0]    ptr;
  logic [s2d_pkg::DIGIT_IDX_W-1:0]    top_idx;
  logic [s2d_pkg::STEP_CNT_W-1:0]     cnt;
  logic [3:0]                         digit;

  // One shift-and-add-three step: correct every digit, then shift a bit in.
  function automatic logic [s2d_pkg::BCD_W-1:0] dabble(
    input logic [s2d_pkg::BCD_W-1:0] b,
    input logic                      bin
  );
    logic [s2d_pkg::BCD_W-1:0] a;
    a = b;
    for (int i = 0; i < s2d_pkg::NUM_DIGITS; i++) begin
      if (a[i*4 +: 4] >= 4'd5) begin
        a[i*4 +: 4] = a[i*4 +: 4] + 4'd3;
      end
    end
    return {a[s2d_pkg::BCD_W-2:0], bin};
  endfunction

  always_comb begin
    bcd_next = dabble(dabble(bcd, shreg[s2d_pkg::DATA_W-1]), shreg[s2d_pkg::DATA_W-2]);
  end

  // Highest non-zero digit; zero itself leaves the units digit.
  always_comb begin
    top_idx = '0;
    for (int i = 1; i < s2d_pkg::NUM_DIGITS; i++) begin
      if (bcd[i*4 +: 4] != 4'd0) begin
        top_idx = s2d_pkg::DIGIT_IDX_W'(i);
      end
    end
  end

  assign digit          = bcd[{ptr, 2'b00} +: 4];
  assign job_ready      = (state == ST_IDLE);
  assign text.valid     = (state == ST_EMIT);
  assign text.character = neg_pend ? s2d_pkg::CHAR_MINUS
                                   : s2d_pkg::CHAR_ZERO + {4'b0000, digit};
  assign text.last      = !neg_pend && (ptr == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (job_valid) begin
            state <= ST_CONV;
          end
        end
        ST_CONV: begin
          if (cnt == '0) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (text.ready && !neg_pend && (ptr == '0)) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        shreg    <= job.mag;
        bcd      <= '0;
        neg_pend <= job.neg;
        cnt      <= s2d_pkg::STEP_CNT_W'(s2d_pkg::CONV_STEPS);
      end
      ST_CONV: begin
        if (cnt != '0) begin
          bcd   <= bcd_next;
          shreg <= {shreg[s2d_pkg::DATA_W-3:0], 2'b00};
          cnt   <= cnt - 1'b1;
        end else begin
          ptr <= top_idx;
        end
      end
      ST_EMIT: begin
        if (text.ready) begin
          if (neg_pend) begin
            neg_pend <= 1'b0;
          end else if (ptr != '0) begin
            ptr <= ptr - 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

endmodule

### sv/s2d_checker.sv
// ----------------------------------------------------------------------------
// s2d_checker
// Watches the text channel of the converter for well-formed numbers.
// ----------------------------------------------------------------------------
`include "signed_int_to_decimal_ascii_macros.svh"

module s2d_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        text_valid,
  input logic                        text_ready,
  input logic [s2d_pkg::CHAR_W-1:0]  text_character,
  input logic                        text_last
);

  logic                              at_start;
  logic [s2d_pkg::CHAR_CNT_W-1:0]    chars;
  logic                              xfer;
  logic                              is_minus;
  logic                              is_digit;

  assign xfer     = text_valid && text_ready;
  assign is_minus = (text_character == s2d_pkg::CHAR_MINUS);
  assign is_digit = (text_character >= s2d_pkg::CHAR_ZERO) &&
                    (text_character <= s2d_pkg::CHAR_ZERO + 8'd9);

  // Track where a number begins: after reset, after a last character, and
  // after a minus sign, a zero character must be the last of its number.
  always_ff @(posedge clk) begin
    if (rst) begin
      at_start <= 1'b1;
      chars    <= '0;
    end else if (xfer) begin
      if (text_last) begin
        at_start <= 1'b1;
        chars    <= '0;
      end else begin
        at_start <= is_minus;
        chars    <= chars + 1'b1;
      end
    end
  end

  `S2D_ASSERT_NEXT(a_stall_holds, clk, rst, text_valid && !text_ready,
    text_valid && $stable(text_character) && $stable(text_last))
  `S2D_ASSERT_SAME(a_legal_char, clk, rst, text_valid,
    (is_minus && !text_last) || is_digit)
  `S2D_ASSERT_SAME(a_no_lead_zero, clk, rst,
    text_valid && at_start && (text_character == s2d_pkg::CHAR_ZERO), text_last)
  `S2D_ASSERT_SAME(a_max_length, clk, rst,
    text_valid && (chars >= s2d_pkg::CHAR_CNT_W'(s2d_pkg::MAX_CHARS - 1)), text_last)

endmodule

bind signed_int_to_decimal_ascii s2d_checker u_s2d_checker (
  .clk            (clk),
  .rst            (rst),
  .text_valid     (text.valid),
  .text_ready     (text.ready),
  .text_character (text.character),
  .text_last      (text.last)
);
